// File: hw/rtl/heat_pump_relay_sequencer_macros.svh
// assertion helpers for the relay sequencer
`ifndef HEAT_PUMP_RELAY_SEQUENCER_MACROS_SVH
`define HEAT_PUMP_RELAY_SEQUENCER_MACROS_SVH

// same-cycle implication, held off during reset
`define HPRS_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, held off during reset
`define HPRS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/hprs_pkg.sv
package hprs_pkg;

    localparam int REG_W     = 24;
    localparam int BYTE_W    = 8;
    localparam int CFG_IDX_W = 2;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_HEARTBEAT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FAN_OVERRUN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INDICATION = 2'd2;

    // register reset values
    localparam logic [REG_W-1:0] HEARTBEAT_RESET  = 24'd60000;
    localparam logic [REG_W-1:0] FAN_OVERRUN_RESET = 24'd3000;
    localparam logic [REG_W-1:0] INDICATION_RESET = 24'd1000;

    // item kinds
    localparam logic OP_TICK    = 1'b0;
    localparam logic OP_MESSAGE = 1'b1;

    // mode characters
    localparam logic [BYTE_W-1:0] MODE_FAN  = 8'h41; // 'A'
    localparam logic [BYTE_W-1:0] MODE_HEAT = 8'h48; // 'H'
    localparam logic [BYTE_W-1:0] MODE_COOL = 8'h43; // 'C'
    localparam logic [BYTE_W-1:0] MODE_OFF  = 8'h5A; // 'Z'

    typedef struct packed {
        logic [REG_W-1:0] heartbeat_timeout_ms;
        logic [REG_W-1:0] fan_overrun_ms;
        logic [REG_W-1:0] indication_ms;
    } cfg_t;

    typedef struct packed {
        logic command_seen;
        logic indication_active;
        logic delayed_fan;
        logic fan;
        logic compressor;
        logic valve;
        logic led;
    } flags_t;

endpackage

// File: hw/rtl/hprs_cfg.sv
module hprs_cfg
    import hprs_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [REG_W-1:0]     cfg_data,
    output cfg_t                 cfg
);

    cfg_t cfg_reg;

    // register file, writes beyond the list are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.heartbeat_timeout_ms <= HEARTBEAT_RESET;
            cfg_reg.fan_overrun_ms       <= FAN_OVERRUN_RESET;
            cfg_reg.indication_ms        <= INDICATION_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_HEARTBEAT:   cfg_reg.heartbeat_timeout_ms <= cfg_data;
                REG_FAN_OVERRUN: cfg_reg.fan_overrun_ms       <= cfg_data;
                REG_INDICATION:  cfg_reg.indication_ms        <= cfg_data;
                default:         cfg_reg                      <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: hw/rtl/hprs_step.sv
module hprs_step
    import hprs_pkg::*;
#(
    parameter int MIN_MESSAGE_BYTES = 1,
    parameter int COUNT_BITS        = 24
)
(
    input  logic                  op,
    input  logic [BYTE_W-1:0]     mode_byte,
    input  logic [BYTE_W-1:0]     message_length,
    input  cfg_t                  cfg,
    input  flags_t                flags,
    input  logic [COUNT_BITS-1:0] since_command,
    input  logic [COUNT_BITS-1:0] since_compressor_off,
    output flags_t                flags_next,
    output logic [COUNT_BITS-1:0] since_command_next,
    output logic [COUNT_BITS-1:0] since_compressor_off_next
);

    localparam int CMP_W = (COUNT_BITS > REG_W) ? COUNT_BITS : REG_W;
    localparam logic [BYTE_W-1:0] MIN_LEN = BYTE_W'(MIN_MESSAGE_BYTES);

    flags_t                f;
    logic [COUNT_BITS-1:0] sc;
    logic [COUNT_BITS-1:0] sco;

    // next state for one tick or one message
    always_comb
    begin
        f   = flags;
        sc  = since_command;
        sco = since_compressor_off;
        unique case (op)
            OP_MESSAGE:
            begin
                if (message_length >= MIN_LEN)
                begin
                    unique case (mode_byte)
                        MODE_FAN:
                        begin
                            f.fan = 1'b1;
                            if (f.compressor)
                            begin
                                f.compressor = 1'b0;
                                f.valve      = 1'b0;
                                sco          = '0;
                            end
                        end
                        MODE_HEAT:
                        begin
                            f.fan        = 1'b1;
                            f.valve      = 1'b0;
                            f.compressor = 1'b1;
                        end
                        MODE_COOL:
                        begin
                            f.fan        = 1'b1;
                            f.valve      = 1'b1;
                            f.compressor = 1'b1;
                        end
                        default:
                        begin
                            // off with delayed fan, or safe shutdown on unknown mode
                            f.delayed_fan = 1'b1;
                            if (f.compressor)
                            begin
                                f.compressor = 1'b0;
                                f.valve      = 1'b0;
                                sco          = '0;
                            end
                        end
                    endcase
                    f.indication_active = 1'b1;
                    f.led               = 1'b1;
                    f.command_seen      = 1'b1;
                    sc                  = '0;
                end
            end
            OP_TICK:
            begin
                // saturating counters
                if (sc != '1)
                begin
                    sc = sc + 1'b1;
                end
                if (sco != '1)
                begin
                    sco = sco + 1'b1;
                end
                // missed heartbeat
                if (f.command_seen &&
                    (CMP_W'(sc) > CMP_W'(cfg.heartbeat_timeout_ms)))
                begin
                    f.delayed_fan = 1'b1;
                    if (f.compressor)
                    begin
                        f.compressor = 1'b0;
                        f.valve      = 1'b0;
                        sco          = '0;
                    end
                end
                // fan overrun expired
                if (f.delayed_fan && !f.compressor &&
                    (CMP_W'(sco) > CMP_W'(cfg.fan_overrun_ms)))
                begin
                    f.fan         = 1'b0;
                    f.delayed_fan = 1'b0;
                end
                // led indication window
                if (f.indication_active)
                begin
                    if (CMP_W'(sc) < CMP_W'(cfg.indication_ms))
                    begin
                        f.led = 1'b1;
                    end
                    else
                    begin
                        f.led               = 1'b0;
                        f.indication_active = 1'b0;
                    end
                end
            end
            default:
            begin
                f = flags;
            end
        endcase
        flags_next                = f;
        since_command_next        = sc;
        since_compressor_off_next = sco;
    end

endmodule

// File: hw/rtl/heat_pump_relay_sequencer.sv
// channel  | direction | handshake          | payload
// in       | input     | in_valid/in_stall   | op, mode_byte, message_length
// out      | output    | out_valid/out_stall | fan_drive, compressor_drive, valve_cooling,
//          |           |                     | led_lit, fan_stop_pending
// cfg      | input     | cfg_write           | cfg_index, cfg_data
//
// one item per cycle sustained while out_stall is low; each result passes the
// input register and then the state/result register, with the next-state logic
// between them
// reset clears state and loads register defaults; no clearing pass
// out_stall holds the result and the state; in_stall rises only while a
// registered item waits behind a stalled result
module heat_pump_relay_sequencer
    import hprs_pkg::*;
#(
    parameter int MIN_MESSAGE_BYTES = 1,
    parameter int COUNT_BITS        = 24
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 op,
    input  logic [BYTE_W-1:0]    mode_byte,
    input  logic [BYTE_W-1:0]    message_length,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic                 fan_drive,
    output logic                 compressor_drive,
    output logic                 valve_cooling,
    output logic                 led_lit,
    output logic                 fan_stop_pending,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [REG_W-1:0]     cfg_data
);

    cfg_t                  cfg;
    logic                  in_valid_reg;
    logic                  op_reg;
    logic [BYTE_W-1:0]     mode_reg;
    logic [BYTE_W-1:0]     length_reg;
    logic                  out_valid_reg;
    flags_t                flags_reg;
    flags_t                flags_next;
    logic [COUNT_BITS-1:0] since_command_reg;
    logic [COUNT_BITS-1:0] since_command_next;
    logic [COUNT_BITS-1:0] since_off_reg;
    logic [COUNT_BITS-1:0] since_off_next;
    logic                  advance;
    logic                  in_take;

    hprs_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // pipeline flow control
    assign advance  = !out_valid_reg || !out_stall;
    assign in_stall = in_valid_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            op_reg     <= op;
            mode_reg   <= mode_byte;
            length_reg <= message_length;
        end
    end

    hprs_step #(
        .MIN_MESSAGE_BYTES (MIN_MESSAGE_BYTES),
        .COUNT_BITS        (COUNT_BITS)
    ) u_step (
        .op                        (op_reg),
        .mode_byte                 (mode_reg),
        .message_length            (length_reg),
        .cfg                       (cfg),
        .flags                     (flags_reg),
        .since_command             (since_command_reg),
        .since_compressor_off      (since_off_reg),
        .flags_next                (flags_next),
        .since_command_next        (since_command_next),
        .since_compressor_off_next (since_off_next)
    );

    // state and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg     <= 1'b0;
            flags_reg         <= '0;
            since_command_reg <= '0;
            since_off_reg     <= '0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
            if (in_valid_reg)
            begin
                flags_reg         <= flags_next;
                since_command_reg <= since_command_next;
                since_off_reg     <= since_off_next;
            end
        end
    end

    // result fields
    assign out_valid        = out_valid_reg;
    assign fan_drive        = flags_reg.fan;
    assign compressor_drive = flags_reg.compressor;
    assign valve_cooling    = flags_reg.valve;
    assign led_lit          = flags_reg.led;
    assign fan_stop_pending = flags_reg.delayed_fan;

`include "heat_pump_relay_sequencer_macros.svh"

    // relay interlocks, led bookkeeping and state hold under a stalled result
    `HPRS_ASSERT_SAME(a_comp_needs_fan, flags_reg.compressor, flags_reg.fan, "compressor on with fan off")
    `HPRS_ASSERT_SAME(a_valve_needs_comp, flags_reg.valve, flags_reg.compressor, "valve set with compressor off")
    `HPRS_ASSERT_SAME(a_led_needs_ind, flags_reg.led, flags_reg.indication_active, "led lit without indication")
    `HPRS_ASSERT_NEXT(a_hold_on_stall, out_valid_reg && out_stall, $stable(flags_reg) && $stable(since_command_reg), "state moved under stalled result")

endmodule
